// ===== rtl/sed_pkg.sv =====
// sed_pkg: shared types, constants and helpers of the sobel edge detector
// depends on nothing; used by sed_sqrt_cell and sobel_edge_detector

package sed_pkg;

  // default frame limits
  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned MaxHeightDef = 4096;

  // field and register widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned CoordW = 12;
  localparam int unsigned DimW   = 13;
  localparam int unsigned ChanW  = 3;
  localparam int unsigned ThrW   = 11;
  localparam int unsigned CfgW   = 13;

  // gray weights, unsigned 16-bit fixed point, summing to 65536
  localparam logic [15:0] GrayWR = 16'd19595;
  localparam logic [15:0] GrayWG = 16'd38470;
  localparam logic [15:0] GrayWB = 16'd7471;
  localparam int unsigned ProdW  = 24;

  // gradient and magnitude
  localparam int unsigned GradW    = 11;  // signed, -1020..1020
  localparam int unsigned SqW      = 20;  // one square, up to 1040400
  localparam int unsigned RadW     = 21;  // sum of squares
  localparam int unsigned SqrtSteps = 11; // one root bit per cell
  localparam int unsigned MagW     = 11;
  localparam logic [PixW-1:0] PixMax = 8'd255;

  // register reset values
  localparam logic [DimW-1:0]  WidthRst   = 13'd640;
  localparam logic [DimW-1:0]  HeightRst  = 13'd480;
  localparam logic [ChanW-1:0] ChanRst    = 3'd3;
  localparam logic [ThrW-1:0]  ThrRst     = 11'd0;

  typedef enum logic [1:0] {
    RegImageWidth    = 2'd0,
    RegImageHeight   = 2'd1,
    RegChannelCount  = 2'd2,
    RegEdgeThreshold = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [CoordW-1:0] out_column;
    logic [CoordW-1:0] out_row;
    logic [PixW-1:0]   edge_value;
    logic              frame_last;
  } res_t;

  // position and frame marker that travel with a pixel
  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              last;
  } meta_t;

  // what one root cell hands to the next
  typedef struct packed {
    meta_t           meta;
    logic [RadW-1:0] rem;
    logic [RadW-1:0] root;
  } sqrt_stage_t;

  // last index of a dimension: clamp to 3..hi, minus one
  function automatic logic [13:0] dim_last(logic [DimW-1:0] v, logic [14:0] hi);
    logic [14:0] c;
    if (v < 13'd3) begin
      c = 15'd3;
    end else if ({2'b00, v} > hi) begin
      c = hi;
    end else begin
      c = {2'b00, v};
    end
    return 14'(c - 15'd1);
  endfunction

endpackage

// ===== rtl/sed_line_ram.sv =====
// sed_line_ram: one bank of the line store, one write and one registered read port
// depends on nothing

module sed_line_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sed_sqrt_cell.sv =====
// sed_sqrt_cell: one cell of the square root chain, settles one root bit
// depends on sed_pkg

module sed_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  sed_pkg::sqrt_stage_t stage_i,
  output logic                 valid_o,
  output sed_pkg::sqrt_stage_t stage_o
);

  localparam int unsigned Shift = 2 * (sed_pkg::SqrtSteps - 1 - Step);
  localparam logic [sed_pkg::RadW:0] Bit = (sed_pkg::RadW + 1)'(1) << Shift;

  logic                   valid_q;
  sed_pkg::sqrt_stage_t   stage_d, stage_q;
  logic [sed_pkg::RadW:0] trial;
  logic                   take;

  always_comb begin
    trial   = {1'b0, stage_i.root} + Bit;
    take    = {1'b0, stage_i.rem} >= trial;
    stage_d = stage_i;
    if (take) begin
      stage_d.rem  = stage_i.rem - trial[sed_pkg::RadW-1:0];
      stage_d.root = (stage_i.root >> 1) + Bit[sed_pkg::RadW-1:0];
    end else begin
      stage_d.root = stage_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== rtl/sobel_edge_detector.sv =====
// sobel_edge_detector: 3x3 sobel edge filter over a raster pixel stream
// depends on sed_pkg, sed_line_ram and sed_sqrt_cell
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, in_data_i (pix_t)  | into block
//   out     | out_valid_o, out_stall_i, out_data_o (res_t)| out of block
//   cfg     | cfg_we_i, cfg_index_i, cfg_data_i          | into block
//
// one pixel transfer per clock sustained while not stalled; an interior result passes, in order,
//   the registers of line store read, window, gradient, squares, 11 root cells
//   and the output register
// the whole pipeline moves together; it holds while a result sits in the
//   output register with out_stall_i high, and in_stall_o is high only then
// reset clears counters, window and valid bits; the line store needs no clear
//   since a row is always written before it is read

module sobel_edge_detector #(
  parameter int unsigned MAX_WIDTH  = sed_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = sed_pkg::MaxHeightDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  sed_pkg::pix_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output sed_pkg::res_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [sed_pkg::CfgW-1:0]   cfg_data_i
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned PixW = sed_pkg::PixW;

  // ---------------------------------------------------------------- config
  logic [sed_pkg::DimW-1:0]  width_q, height_q;
  logic [sed_pkg::ChanW-1:0] chan_q;
  logic [sed_pkg::ThrW-1:0]  thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sed_pkg::WidthRst;
      height_q <= sed_pkg::HeightRst;
      chan_q   <= sed_pkg::ChanRst;
      thr_q    <= sed_pkg::ThrRst;
    end else if (cfg_we_i) begin
      case (sed_pkg::cfg_reg_e'(cfg_index_i))
        sed_pkg::RegImageWidth:    width_q  <= cfg_data_i;
        sed_pkg::RegImageHeight:   height_q <= cfg_data_i;
        sed_pkg::RegChannelCount:  chan_q   <= cfg_data_i[sed_pkg::ChanW-1:0];
        sed_pkg::RegEdgeThreshold: thr_q    <= cfg_data_i[sed_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // geometry writes restart the frame
  logic geom_wr;
  assign geom_wr = cfg_we_i &&
                   (cfg_index_i == sed_pkg::RegImageWidth ||
                    cfg_index_i == sed_pkg::RegImageHeight);

  logic [13:0]     col_last_full, row_last_full;
  logic [ColW-1:0] last_col;
  logic [RowW-1:0] last_row;

  assign col_last_full = sed_pkg::dim_last(width_q, 15'(MAX_WIDTH));
  assign row_last_full = sed_pkg::dim_last(height_q, 15'(MAX_HEIGHT));
  assign last_col      = col_last_full[ColW-1:0];
  assign last_row      = row_last_full[RowW-1:0];

  // --------------------------------------------------------------- handshake
  logic advance, in_accept;
  logic out_valid_q;
  sed_pkg::res_t out_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;
  assign in_accept  = in_valid_i && advance;

  // ---------------------------------------------------------- raster position
  logic [ColW-1:0] col_cnt_q;
  logic [RowW-1:0] row_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (geom_wr) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_accept) begin
      if (col_cnt_q == last_col) begin
        col_cnt_q <= '0;
        row_cnt_q <= (row_cnt_q == last_row) ? '0 : row_cnt_q + RowW'(1);
      end else begin
        col_cnt_q <= col_cnt_q + ColW'(1);
      end
    end
  end

  // ---------------------------------------- stage 1: weights and line read
  logic [PixW-1:0] g_sel, b_sel;
  logic            emit_d;
  sed_pkg::meta_t  meta_d;

  always_comb begin
    // fewer channels: missing samples repeat red
    g_sel = (chan_q < 3'd2) ? in_data_i.red : in_data_i.green;
    b_sel = (chan_q < 3'd3) ? in_data_i.red : in_data_i.blue;
    emit_d = (col_cnt_q >= ColW'(2)) && (row_cnt_q >= RowW'(2));
    meta_d.col  = sed_pkg::CoordW'(col_cnt_q - ColW'(1));
    meta_d.row  = sed_pkg::CoordW'(row_cnt_q - RowW'(1));
    meta_d.last = (col_cnt_q == last_col) && (row_cnt_q == last_row);
  end

  logic                        s1_valid_q, s1_emit_q;
  logic [ColW-1:0]             s1_addr_q;
  sed_pkg::meta_t              s1_meta_q;
  logic [sed_pkg::ProdW-1:0]   pr_q, pg_q, pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_emit_q <= emit_d;
      s1_addr_q <= col_cnt_q;
      s1_meta_q <= meta_d;
      pr_q <= sed_pkg::ProdW'(sed_pkg::GrayWR) * sed_pkg::ProdW'(in_data_i.red);
      pg_q <= sed_pkg::ProdW'(sed_pkg::GrayWG) * sed_pkg::ProdW'(g_sel);
      pb_q <= sed_pkg::ProdW'(sed_pkg::GrayWB) * sed_pkg::ProdW'(b_sel);
    end
  end

  // two banks: top holds the row two above, mid the row just above
  logic [PixW-1:0] top_rd, mid_rd, gray;
  logic [sed_pkg::ProdW-1:0] gray_sum;
  logic            line_we;

  assign gray_sum = pr_q + pg_q + pb_q;
  assign gray     = gray_sum[sed_pkg::ProdW-1:sed_pkg::ProdW-PixW];
  assign line_we  = advance && s1_valid_q;

  sed_line_ram #(.Depth(MAX_WIDTH), .AddrW(ColW)) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_addr_q),
    .wdata_i (mid_rd),
    .re_i    (advance),
    .raddr_i (col_cnt_q),
    .rdata_o (top_rd)
  );

  sed_line_ram #(.Depth(MAX_WIDTH), .AddrW(ColW)) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_addr_q),
    .wdata_i (gray),
    .re_i    (advance),
    .raddr_i (col_cnt_q),
    .rdata_o (mid_rd)
  );

  // ------------------------------------------------------ stage 2: window
  logic [PixW-1:0] win_q [3][3];
  logic            w_valid_q;
  sed_pkg::meta_t  w_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (advance) begin
      w_valid_q <= s1_valid_q && s1_emit_q;
      if (s1_valid_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= top_rd;
        win_q[1][2] <= mid_rd;
        win_q[2][2] <= gray;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      w_meta_q <= s1_meta_q;
    end
  end

  // ---------------------------------------------------- stage 3: gradients
  logic signed [sed_pkg::GradW-1:0] p [3][3];
  logic signed [sed_pkg::GradW-1:0] gx_d, gy_d, gx_q, gy_q;
  logic                             g_valid_q;
  sed_pkg::meta_t                   g_meta_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p[r][c] = $signed({3'b000, win_q[r][c]});
      end
    end
    gx_d = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) + (p[2][2] - p[2][0]);
    gy_d = (p[2][0] - p[0][0]) + ((p[2][1] - p[0][1]) <<< 1) + (p[2][2] - p[0][2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
    end else if (advance) begin
      g_valid_q <= w_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      gx_q     <= gx_d;
      gy_q     <= gy_d;
      g_meta_q <= w_meta_q;
    end
  end

  // ------------------------------------------------------ stage 4: squares
  logic signed [2*sed_pkg::GradW-1:0] sqx, sqy;
  logic [sed_pkg::SqW-1:0]            sqx_q, sqy_q;
  logic                               sq_valid_q;
  sed_pkg::meta_t                     sq_meta_q;

  assign sqx = gx_q * gx_q;
  assign sqy = gy_q * gy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (advance) begin
      sq_valid_q <= g_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sqx_q     <= sqx[sed_pkg::SqW-1:0];
      sqy_q     <= sqy[sed_pkg::SqW-1:0];
      sq_meta_q <= g_meta_q;
    end
  end

  // ------------------------------------------------------ root cell chain
  logic                 cv [sed_pkg::SqrtSteps+1];
  sed_pkg::sqrt_stage_t cs [sed_pkg::SqrtSteps+1];
  sed_pkg::sqrt_stage_t root_in;

  always_comb begin
    root_in.meta = sq_meta_q;
    root_in.rem  = {1'b0, sqx_q} + {1'b0, sqy_q};
    root_in.root = '0;
  end

  assign cv[0] = sq_valid_q;
  assign cs[0] = root_in;

  for (genvar i = 0; i < sed_pkg::SqrtSteps; i++) begin : g_root
    sed_sqrt_cell #(.Step(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (cv[i]),
      .stage_i (cs[i]),
      .valid_o (cv[i+1]),
      .stage_o (cs[i+1])
    );
  end

  // --------------------------------------------- output: clamp or threshold
  logic [sed_pkg::MagW-1:0] mag;
  sed_pkg::res_t            res_d;

  always_comb begin
    mag              = cs[sed_pkg::SqrtSteps].root[sed_pkg::MagW-1:0];
    res_d.out_column = cs[sed_pkg::SqrtSteps].meta.col;
    res_d.out_row    = cs[sed_pkg::SqrtSteps].meta.row;
    res_d.frame_last = cs[sed_pkg::SqrtSteps].meta.last;
    if (thr_q != '0) begin
      res_d.edge_value = (mag >= thr_q) ? sed_pkg::PixMax : '0;
    end else if (mag > sed_pkg::MagW'(sed_pkg::PixMax)) begin
      res_d.edge_value = sed_pkg::PixMax;
    end else begin
      res_d.edge_value = mag[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= cv[sed_pkg::SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------- checks
  // raster position never runs past the frame
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_cnt_q <= last_col && row_cnt_q <= last_row)
    else $error("raster position beyond frame");

  // line store write and new read never hit the same entry
  a_no_line_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && in_accept && !$past(cfg_we_i)) |-> s1_addr_q != col_cnt_q)
    else $error("line store read and write collide");

  // threshold mode gives only full or empty
  a_binary_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && thr_q != '0) |->
      (out_data_o.edge_value == sed_pkg::PixMax || out_data_o.edge_value == '0))
    else $error("threshold output not binary");

  // frame end marks the last interior column
  a_last_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_last) |->
      out_data_o.out_column == sed_pkg::CoordW'(last_col - ColW'(1)))
    else $error("frame end on wrong column");

endmodule
